### rtl/irm_pkg.sv
// Shared types and constants for the ICMP reply matcher.
`timescale 1ns / 1ps

package irm_pkg;

	localparam int MAX_PACKET_BYTES = 512;
	// Position counter holds MAX_PACKET_BYTES itself once saturated.
	localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
	// Inner ICMP header can start as late as 60 + 8 + 60, its id/seq end 7 bytes further.
	localparam int CMP_W = (POS_W > 9) ? POS_W : 9;

	localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
	localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
	localparam logic [7:0] QUOTE_GAP          = 8'd8;

	typedef enum logic [1:0] {
		KIND_OTHER         = 2'd0,
		KIND_ECHO_REPLY    = 2'd1,
		KIND_TIME_EXCEEDED = 2'd2
	} reply_kind_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [15:0] expected_sequence;
	} in_req_t;

	typedef struct packed {
		logic       matched;
		logic [1:0] reply_kind;
		logic       truncated;
	} out_rsp_t;

	typedef struct packed {
		logic [POS_W-1:0] byte_position;
		logic [5:0]       icmp_offset;
		logic [7:0]       inner_icmp_offset;
		logic [7:0]       message_type;
		logic [15:0]      captured_ident;
		logic [15:0]      captured_sequence;
		logic [15:0]      awaited_sequence;
		logic             fields_seen;
	} pkt_state_t;

endpackage

### rtl/irm_step.sv
// Per-byte parse step: next packet state and the end-of-packet result.
`timescale 1ns / 1ps

module irm_step import irm_pkg::*; (
	input  pkt_state_t  cur,
	input  in_req_t     req,
	input  logic [15:0] probe_ident,
	output pkt_state_t  nxt,
	output out_rsp_t    rsp
);

	logic [POS_W-1:0] pos;
	logic [POS_W-1:0] off_ext;
	logic [POS_W-1:0] rel;
	logic [CMP_W-1:0] pos_wide;
	logic [CMP_W-1:0] inner_wide;
	logic [CMP_W-1:0] inner_rel;
	logic             cap_en;
	logic [1:0]       cap_sel;
	logic             type_read;
	reply_kind_t      kind;

	always_comb begin
		nxt        = cur;
		pos        = cur.byte_position;
		off_ext    = '0;
		rel        = '0;
		pos_wide   = CMP_W'(pos);
		inner_wide = CMP_W'(cur.inner_icmp_offset);
		inner_rel  = pos_wide - inner_wide;
		cap_en     = 1'b0;
		cap_sel    = 2'd0;

		if (pos < POS_W'(MAX_PACKET_BYTES)) begin
			if (pos == '0) begin
				nxt.awaited_sequence = req.expected_sequence;
				nxt.icmp_offset      = {req.data_byte[3:0], 2'b00};
			end
			off_ext = POS_W'(nxt.icmp_offset);
			rel     = pos - off_ext;

			if (pos == off_ext) begin
				nxt.message_type = req.data_byte;
				if (req.data_byte != TYPE_ECHO_REPLY && req.data_byte != TYPE_TIME_EXCEEDED)
					nxt.fields_seen = 1'b1;
			end else if (pos > off_ext) begin
				if (cur.message_type == TYPE_ECHO_REPLY) begin
					if (rel >= POS_W'(4) && rel <= POS_W'(7)) begin
						cap_en  = 1'b1;
						cap_sel = rel[1:0];
					end
				end else if (cur.message_type == TYPE_TIME_EXCEEDED) begin
					if (rel == POS_W'(QUOTE_GAP)) begin
						nxt.inner_icmp_offset = {2'b00, nxt.icmp_offset} + QUOTE_GAP
							+ {2'b00, req.data_byte[3:0], 2'b00};
					end else if (rel > POS_W'(QUOTE_GAP)
							&& pos_wide >= inner_wide + CMP_W'(4)
							&& pos_wide <= inner_wide + CMP_W'(7)) begin
						cap_en  = 1'b1;
						cap_sel = inner_rel[1:0];
					end
				end
			end

			// id and seq live at header bytes 4..7, low two bits pick the byte
			if (cap_en) begin
				case (cap_sel)
					2'd0: nxt.captured_ident[15:8] = req.data_byte;
					2'd1: nxt.captured_ident[7:0] = req.data_byte;
					2'd2: nxt.captured_sequence[15:8] = req.data_byte;
					2'd3: begin
						nxt.captured_sequence[7:0] = req.data_byte;
						nxt.fields_seen = 1'b1;
					end
					default: nxt.fields_seen = nxt.fields_seen;
				endcase
			end

			nxt.byte_position = pos + POS_W'(1);
		end
	end

	always_comb begin
		type_read = nxt.byte_position > POS_W'(nxt.icmp_offset);
		kind      = KIND_OTHER;
		if (type_read) begin
			if (nxt.message_type == TYPE_ECHO_REPLY)
				kind = KIND_ECHO_REPLY;
			else if (nxt.message_type == TYPE_TIME_EXCEEDED)
				kind = KIND_TIME_EXCEEDED;
		end
		rsp.matched    = nxt.fields_seen && kind != KIND_OTHER
			&& nxt.captured_ident == probe_ident
			&& nxt.captured_sequence == nxt.awaited_sequence;
		rsp.reply_kind = kind;
		rsp.truncated  = ~nxt.fields_seen;
	end

endmodule

### rtl/icmp_reply_matcher_core.sv
// Top level of the ICMP reply matcher: input register, parse step, result register.
//
//  channel | signals                      | payload     | direction
//  --------+------------------------------+-------------+----------
//  in      | in_valid / in_stall          | in_req_t    | into core
//  out     | out_valid / out_stall        | out_rsp_t   | out of core
//  cfg     | cfg_we                       | cfg_data    | into core
//
// One packet byte is taken per cycle while in_stall is low. A byte is registered
// in the input register and parsed there against the packet state; a last byte's
// result is then registered in the result register.
// Reset clears the packet state and probe_ident to zero.
// in_stall rises only when a last byte waits in the input register while an
// earlier result is still stalled at the output.
`timescale 1ns / 1ps

module icmp_reply_matcher_core import irm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_req_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_rsp_t    out_data
);

	logic [15:0] probe_ident_q;
	logic        valid_s1;
	in_req_t     req_s1;
	pkt_state_t  state_q;
	pkt_state_t  state_nxt;
	out_rsp_t    rsp_nxt;
	logic        out_valid_q;
	out_rsp_t    rsp_q;
	logic        out_free;
	logic        adv_s1;
	logic        in_acc;

	irm_step u_step (
		.cur         (state_q),
		.req         (req_s1),
		.probe_ident (probe_ident_q),
		.nxt         (state_nxt),
		.rsp         (rsp_nxt)
	);

	assign out_free  = ~out_valid_q | ~out_stall;
	// a byte with no result never waits on the output side
	assign adv_s1    = valid_s1 & (~req_s1.last_byte | out_free);
	assign in_stall  = valid_s1 & ~adv_s1;
	assign in_acc    = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_ident_q <= '0;
		end else if (cfg_we) begin
			probe_ident_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			req_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= req_s1.last_byte ? '0 : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && req_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req_s1.last_byte)
			rsp_q <= rsp_nxt;
	end

endmodule
